[design/tfc_pkg.sv]
`default_nettype none

package tfc_pkg;

    // field widths
    localparam int TEMP_W = 12;
    localparam int PCT_W  = 7;
    localparam int DUTY_W = 10;

    // average keeps extra fraction bits below 1/16 degree
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = TEMP_W + FRAC_BITS;

    // smoothing factor 9830 / 2^16
    localparam int ALPHA_NUM   = 9830;
    localparam int ALPHA_W     = 15;
    localparam int ALPHA_SHIFT = 16;
    localparam int PROD_W      = ACC_W + 1 + ALPHA_SHIFT + 1;

    // proportional band divider
    localparam int NUM_W      = ACC_W + 8;
    localparam int QCNT_W     = $clog2(PCT_W + 1);
    localparam int BAND_SCALE = 200;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // duty = pct * DUTY_FULL_SCALE / 100, division by reciprocal multiply
    localparam int DUTY_FULL_SCALE = 1023;
    localparam int DUTY_X_W        = $clog2(100 * DUTY_FULL_SCALE + 1);
    localparam int RECIP_SHIFT     = DUTY_X_W + 7;
    localparam longint DUTY_RECIP  = ((64'd1 << RECIP_SHIFT) / 100) + 1;
    localparam int RECIP_W         = RECIP_SHIFT - 5;
    localparam int DUTY_P_W        = DUTY_X_W + RECIP_W + DUTY_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TEMP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FAN_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_PCT  = 2'd3;

    localparam logic                   FAN_MODE_RESET    = 1'b0;
    localparam logic [TEMP_W-1:0]      DESIRED_RESET     = TEMP_W'(384);
    localparam logic [TEMP_W-1:0]      MAX_RESET         = TEMP_W'(512);
    localparam logic [PCT_W-1:0]       MANUAL_PCT_RESET  = PCT_W'(0);

    localparam logic MODE_AUTO = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic load_sample;
        logic mult;
        logic round;
        logic update;
        logic decide;
        logic duty_mul;
        logic duty_scale;
        logic out_load;
    } tfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic band;
    } tfc_sts_t;

endpackage

`default_nettype wire

[design/tfc_in_if.sv]
`default_nettype none

interface tfc_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [tfc_pkg::TEMP_W-1:0]        temp_sample;

    modport source (output valid, output temp_sample, input ready);
    modport sink   (input valid, input temp_sample, output ready);
endinterface

`default_nettype wire

[design/tfc_out_if.sv]
`default_nettype none

interface tfc_out_if;
    logic                                     valid;
    logic                                     ready;
    logic        [tfc_pkg::PCT_W-1:0]         fan_percent;
    logic        [tfc_pkg::DUTY_W-1:0]        fan_duty;
    logic                                     alarm_on;
    logic                                     alarm_led;
    logic signed [tfc_pkg::TEMP_W-1:0]        avg_temp;

    modport source (output valid, output fan_percent, output fan_duty,
                    output alarm_on, output alarm_led, output avg_temp,
                    input ready);
    modport sink   (input valid, input fan_percent, input fan_duty,
                    input alarm_on, input alarm_led, input avg_temp,
                    output ready);
endinterface

`default_nettype wire

[design/tfc_div.sv]
`default_nettype none

module tfc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tfc_pkg::NUM_W-1:0]   num,
    input  wire logic [tfc_pkg::NUM_W-1:0]   den,
    output logic                             done,
    output logic [tfc_pkg::PCT_W-1:0]        quo
);

    logic [tfc_pkg::NUM_W-1:0]  rem_reg,    rem_next;
    logic [tfc_pkg::NUM_W-1:0]  dsh_reg,    dsh_next;
    logic [tfc_pkg::PCT_W-1:0]  quo_reg,    quo_next;
    logic [tfc_pkg::QCNT_W-1:0] cnt_reg,    cnt_next;
    logic                       busy_reg,   busy_next;
    logic                       done_reg,   done_next;
    logic                       fits;

    // one restoring step per cycle, most significant quotient bit first
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = den << (tfc_pkg::PCT_W - 1);
            quo_next  = '0;
            cnt_next  = tfc_pkg::QCNT_W'(tfc_pkg::PCT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[tfc_pkg::PCT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tfc_pkg::QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[design/tfc_datapath.sv]
`default_nettype none

module tfc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tfc_pkg::tfc_cmd_t                   cmd,
    output tfc_pkg::tfc_sts_t                        sts,
    input  wire logic signed [tfc_pkg::TEMP_W-1:0]   temp_sample,
    input  wire logic                                cfg_we,
    input  wire logic [tfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tfc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [tfc_pkg::NUM_W-1:0]                div_num,
    output logic [tfc_pkg::NUM_W-1:0]                div_den,
    input  wire logic [tfc_pkg::PCT_W-1:0]           div_quo,
    output logic [tfc_pkg::PCT_W-1:0]                fan_percent,
    output logic [tfc_pkg::DUTY_W-1:0]               fan_duty,
    output logic                                     alarm_on,
    output logic                                     alarm_led,
    output logic signed [tfc_pkg::TEMP_W-1:0]        avg_temp
);

    localparam int AW = tfc_pkg::ACC_W;
    localparam int FB = tfc_pkg::FRAC_BITS;

    localparam logic signed [tfc_pkg::ALPHA_W-1:0] ALPHA =
        tfc_pkg::ALPHA_W'(tfc_pkg::ALPHA_NUM);
    localparam logic signed [tfc_pkg::PROD_W-1:0] PROD_HALF =
        tfc_pkg::PROD_W'(1) << (tfc_pkg::ALPHA_SHIFT - 1);
    localparam logic signed [AW:0] FILT_HALF = (AW+1)'(1) << (FB - 1);
    localparam logic signed [AW+1:0] ACC_LO =
        {3'b111, {(AW-1){1'b0}}};
    localparam logic signed [AW+1:0] ACC_HI =
        {3'b000, {(tfc_pkg::TEMP_W-1){1'b1}}, {FB{1'b0}}};
    localparam logic [tfc_pkg::DUTY_X_W-1:0] DUTY_SCALE =
        tfc_pkg::DUTY_X_W'(tfc_pkg::DUTY_FULL_SCALE);
    localparam logic [tfc_pkg::RECIP_W-1:0] RECIP =
        tfc_pkg::RECIP_W'(tfc_pkg::DUTY_RECIP);
    localparam logic [tfc_pkg::NUM_W-1:0] NUM_SCALE =
        tfc_pkg::NUM_W'(tfc_pkg::BAND_SCALE);

    // configuration registers
    logic                              mode_reg;
    logic [tfc_pkg::TEMP_W-1:0]        desired_reg;
    logic [tfc_pkg::TEMP_W-1:0]        max_reg;
    logic [tfc_pkg::PCT_W-1:0]         manual_reg;

    // filter state
    logic signed [AW-1:0]              acc_reg,   acc_next;
    logic                              primed_reg;
    logic                              led_reg,   led_next;

    // working registers
    logic signed [tfc_pkg::TEMP_W-1:0] sample_reg;
    logic signed [tfc_pkg::PROD_W-1:0] prod_reg,  prod_next;
    logic signed [AW:0]                delta_reg, delta_next;
    logic                              alarm_reg, alarm_next;
    logic                              band_reg,  band_next;
    logic [tfc_pkg::PCT_W-1:0]         base_reg,  base_next;
    logic signed [tfc_pkg::TEMP_W-1:0] filt_reg,  filt_next;
    logic [tfc_pkg::NUM_W-1:0]         num_reg,   num_next;
    logic [tfc_pkg::NUM_W-1:0]         den_reg,   den_next;
    logic [tfc_pkg::PCT_W-1:0]         pct_reg,   pct_next;
    logic [tfc_pkg::DUTY_X_W-1:0]      x_reg,     x_next;
    logic [tfc_pkg::DUTY_P_W-1:0]      dprod_reg, dprod_next;

    // result register
    logic [tfc_pkg::PCT_W-1:0]         out_pct_reg;
    logic [tfc_pkg::DUTY_W-1:0]        out_duty_reg;
    logic                              out_alarm_reg;
    logic                              out_led_reg;
    logic signed [tfc_pkg::TEMP_W-1:0] out_filt_reg;

    logic signed [AW-1:0]              sample_fx;
    logic signed [AW-1:0]              d_fx;
    logic signed [AW-1:0]              m_fx;
    logic signed [AW:0]                diff;
    logic signed [tfc_pkg::PROD_W-1:0] prod_rnd;
    logic signed [AW+1:0]              sum;
    logic signed [AW+1:0]              sum_clamped;
    logic signed [AW:0]                above_d;
    logic signed [AW:0]                span;
    logic signed [AW:0]                filt_sum;
    logic                              at_or_below_d;
    logic                              at_or_above_m;
    logic [tfc_pkg::PCT_W-1:0]         manual_sat;

    assign sample_fx = {sample_reg, {FB{1'b0}}};
    assign d_fx      = {desired_reg, {FB{1'b0}}};
    assign m_fx      = {max_reg, {FB{1'b0}}};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tfc_pkg::FAN_MODE_RESET;
            desired_reg <= tfc_pkg::DESIRED_RESET;
            max_reg     <= tfc_pkg::MAX_RESET;
            manual_reg  <= tfc_pkg::MANUAL_PCT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tfc_pkg::CFG_FAN_MODE:   mode_reg    <= cfg_data[0];
                tfc_pkg::CFG_DESIRED:    desired_reg <= cfg_data[tfc_pkg::TEMP_W-1:0];
                tfc_pkg::CFG_MAX:        max_reg     <= cfg_data[tfc_pkg::TEMP_W-1:0];
                tfc_pkg::CFG_MANUAL_PCT: manual_reg  <= cfg_data[tfc_pkg::PCT_W-1:0];
            endcase
        end
    end

    // error times alpha
    assign diff      = (AW+1)'(sample_fx) - (AW+1)'(acc_reg);
    assign prod_next = diff * ALPHA;

    // round half up, arithmetic shift floors
    assign prod_rnd   = prod_reg + PROD_HALF;
    assign delta_next = prod_rnd[tfc_pkg::ALPHA_SHIFT +: AW+1];

    // new average, clamped to the sample range; the first sample loads it directly
    always_comb
    begin
        sum = (AW+2)'(acc_reg) + (AW+2)'(delta_reg);
        if (sum < ACC_LO)
        begin
            sum_clamped = ACC_LO;
        end
        else if (sum > ACC_HI)
        begin
            sum_clamped = ACC_HI;
        end
        else
        begin
            sum_clamped = sum;
        end
        acc_next = primed_reg ? sum_clamped[AW-1:0] : sample_fx;
    end

    // fan curve decisions on the updated average
    assign at_or_below_d = (acc_reg <= d_fx);
    assign at_or_above_m = (acc_reg >= m_fx);
    assign manual_sat    = (manual_reg > tfc_pkg::PCT_FULL) ? tfc_pkg::PCT_FULL
                                                            : manual_reg;
    assign above_d       = (AW+1)'(acc_reg) - (AW+1)'(d_fx);
    assign span          = (AW+1)'(m_fx) - (AW+1)'(d_fx);
    assign filt_sum      = (AW+1)'(acc_reg) + FILT_HALF;

    always_comb
    begin
        alarm_next = (acc_reg > m_fx);
        band_next  = 1'b0;
        led_next   = alarm_next ? ~led_reg : 1'b0;
        if (alarm_next)
        begin
            base_next = tfc_pkg::PCT_FULL;
        end
        else if (mode_reg != tfc_pkg::MODE_AUTO)
        begin
            base_next = manual_sat;
        end
        else if (at_or_below_d)
        begin
            base_next = '0;
        end
        else
        begin
            base_next = tfc_pkg::PCT_FULL;
            band_next = !at_or_above_m;
        end
        num_next  = tfc_pkg::NUM_W'(above_d[AW-1:0]) * NUM_SCALE
                  + tfc_pkg::NUM_W'(span[AW-1:0]);
        den_next  = tfc_pkg::NUM_W'(span[AW-1:0]) << 1;
        filt_next = filt_sum[FB +: tfc_pkg::TEMP_W];
    end

    // duty scaling
    assign pct_next   = band_reg ? div_quo : base_reg;
    assign x_next     = tfc_pkg::DUTY_X_W'(pct_next) * DUTY_SCALE;
    assign dprod_next = tfc_pkg::DUTY_P_W'(x_reg) * tfc_pkg::DUTY_P_W'(RECIP);

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            primed_reg <= 1'b0;
            led_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                acc_reg    <= acc_next;
                primed_reg <= 1'b1;
            end
            if (cmd.decide)
            begin
                led_reg <= led_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= temp_sample;
        end
        if (cmd.mult)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.round)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.decide)
        begin
            alarm_reg <= alarm_next;
            base_reg  <= base_next;
            filt_reg  <= filt_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
        end
        if (cmd.duty_mul)
        begin
            pct_reg <= pct_next;
            x_reg   <= x_next;
        end
        if (cmd.duty_scale)
        begin
            dprod_reg <= dprod_next;
        end
        if (cmd.out_load)
        begin
            out_pct_reg   <= pct_reg;
            out_duty_reg  <= dprod_reg[tfc_pkg::RECIP_SHIFT +: tfc_pkg::DUTY_W];
            out_alarm_reg <= alarm_reg;
            out_led_reg   <= led_reg;
            out_filt_reg  <= filt_reg;
        end
    end

    // band flag is control, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            band_reg <= band_next;
        end
    end

    assign sts.band    = band_reg;
    assign div_num     = num_reg;
    assign div_den     = den_reg;
    assign fan_percent = out_pct_reg;
    assign fan_duty    = out_duty_reg;
    assign alarm_on    = out_alarm_reg;
    assign alarm_led   = out_led_reg;
    assign avg_temp    = out_filt_reg;

endmodule

`default_nettype wire

[design/tfc_ctrl.sv]
`default_nettype none

module tfc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tfc_pkg::tfc_cmd_t        cmd,
    input  wire tfc_pkg::tfc_sts_t   sts,
    output logic                     div_start,
    input  wire logic                div_done
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MULT   = 4'd1;
    localparam logic [3:0] S_ROUND  = 4'd2;
    localparam logic [3:0] S_UPDATE = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_BRANCH = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DUTY1  = 4'd7;
    localparam logic [3:0] S_DUTY2  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (sts.band)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DUTY1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DUTY1;
                end
            end
            S_DUTY1:
            begin
                cmd.duty_mul = 1'b1;
                state_next   = S_DUTY2;
            end
            S_DUTY2:
            begin
                cmd.duty_scale = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[design/thermal_fan_controller_ema_top.sv]
// steps: load, multiply, round, update average, decide, divide in the band,
// duty scaling, result load; one sample in flight (7-step serial divider)
// a new sample is taken while the previous result beat still waits downstream
// reset: average cleared and unprimed, led off, registers at 0 / 384 / 512 / 0
`default_nettype none

module thermal_fan_controller_ema_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    tfc_in_if.sink                                   sample,
    tfc_out_if.source                                result,
    input  wire logic                                cfg_we,
    input  wire logic [tfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tfc_pkg::tfc_cmd_t                cmd;
    tfc_pkg::tfc_sts_t                sts;
    logic                             div_start;
    logic                             div_done;
    logic [tfc_pkg::NUM_W-1:0]        div_num;
    logic [tfc_pkg::NUM_W-1:0]        div_den;
    logic [tfc_pkg::PCT_W-1:0]        div_quo;

    // sequencer
    tfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts),
        .div_start (div_start),
        .div_done  (div_done)
    );

    // filter, fan curve and duty scaling
    tfc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .temp_sample   (sample.temp_sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .div_num       (div_num),
        .div_den       (div_den),
        .div_quo       (div_quo),
        .fan_percent   (result.fan_percent),
        .fan_duty      (result.fan_duty),
        .alarm_on      (result.alarm_on),
        .alarm_led     (result.alarm_led),
        .avg_temp      (result.avg_temp)
    );

    // proportional band ratio
    tfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule

`default_nettype wire

[sim/thermal_fan_controller_ema_top_tb.sv]
`timescale 1ns / 100ps

module thermal_fan_controller_ema_top_tb;

    import tfc_pkg::*;

    localparam int  SMOOTH_NUM   = 9830;
    localparam int  SMOOTH_SHIFT = 16;
    localparam int  DUTY_SCALE   = 1023;
    localparam int  SETTLE       = 24;
    localparam int  RANDOM_ITEMS = 850;

    // one result beat as seen on the output channel
    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [DUTY_W-1:0] duty;
        logic              alarm;
        logic              led;
        logic [TEMP_W-1:0] filt;
    } fan_result_t;

    // fan curve predictor and store of expected results
    class fan_scoreboard;
        fan_result_t       expected_q[$];
        logic              mode;
        logic [TEMP_W-1:0] desired;
        logic [TEMP_W-1:0] maxt;
        logic [PCT_W-1:0]  manual;
        longint            avg_acc;
        bit                primed;
        bit                led;
        int                errors;
        int                checked;
        int                alarms;
        int                band_hits;

        function new();
            mode    = FAN_MODE_RESET;
            desired = DESIRED_RESET;
            maxt    = MAX_RESET;
            manual  = MANUAL_PCT_RESET;
            avg_acc = 0;
            primed  = 0;
            led     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FAN_MODE:   mode = data[0];
                CFG_DESIRED:    desired = data[TEMP_W-1:0];
                CFG_MAX:        maxt = data[TEMP_W-1:0];
                CFG_MANUAL_PCT: manual = data[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // average update, alarm, fan curve and duty for one sample beat
        function void note_sample(logic signed [TEMP_W-1:0] t);
            longint      one;
            longint      smp;
            longint      d;
            longint      m;
            longint      prod;
            longint      span;
            longint      num;
            longint      filt;
            int          pct;
            bit          alarm;
            fan_result_t r;
            one = longint'(1) << FRAC_BITS;
            smp = longint'(t) * one;
            d   = longint'($signed(desired)) * one;
            m   = longint'($signed(maxt)) * one;

            // first sample loads the average directly
            if (!primed)
            begin
                avg_acc = smp;
                primed  = 1;
            end
            else
            begin
                prod    = (smp - avg_acc) * SMOOTH_NUM;
                avg_acc = avg_acc + ((prod + (longint'(1) << (SMOOTH_SHIFT - 1))) >>> SMOOTH_SHIFT);
            end
            if (avg_acc < -2048 * one)
                avg_acc = -2048 * one;
            if (avg_acc > 2047 * one)
                avg_acc = 2047 * one;

            // alarm overrides both fan modes
            alarm = avg_acc > m;
            if (alarm)
            begin
                pct = 100;
                led = !led;
                alarms++;
            end
            else
            begin
                if (mode == MODE_AUTO)
                begin
                    if (avg_acc <= d)
                        pct = 0;
                    else if (avg_acc >= m)
                        pct = 100;
                    else
                    begin
                        span = m - d;
                        num  = 200 * (avg_acc - d) + span;
                        pct  = int'(num / (2 * span));
                        if (pct > 100)
                            pct = 100;
                        band_hits++;
                    end
                end
                else
                    pct = (manual > 100) ? 100 : int'(manual);
                led = 0;
            end

            // filtered value rounded half up to 1/16 degree
            filt = (avg_acc + (one >>> 1)) >>> FRAC_BITS;
            if (filt < -2048)
                filt = -2048;
            if (filt > 2047)
                filt = 2047;

            r.pct   = PCT_W'(pct);
            r.duty  = DUTY_W'((pct * DUTY_SCALE) / 100);
            r.alarm = alarm;
            r.led   = led;
            r.filt  = TEMP_W'(filt);
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string field, int want_v, int got_v);
            if (want_v != got_v)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d, actual %0d",
                         $time, field, want_v, got_v);
            end
        endfunction

        function void check_result(fan_result_t got);
            fan_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: expected none, actual pct %0d filt %0d",
                         $time, got.pct, $signed(got.filt));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            cmp_field("fan_percent", want.pct, got.pct);
            cmp_field("fan_duty", want.duty, got.duty);
            cmp_field("alarm_on", want.alarm, got.alarm);
            cmp_field("alarm_led", want.led, got.led);
            cmp_field("avg_temp", $signed(want.filt), $signed(got.filt));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tfc_in_if  sample_if();
    tfc_out_if result_if();

    fan_scoreboard sb;
    bit            tx_calm;
    bit            rx_calm;
    int            items_sent;
    int            phases;
    int            band_lo;
    int            band_hi;

    thermal_fan_controller_ema_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int clamp12(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int pick_temp();
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 2640)) - 640;
    endfunction

    // one sample beat, with a random gap ahead of it
    task automatic send_sample(input logic signed [TEMP_W-1:0] t);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 14));
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.temp_sample <= t;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note_sample(t);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] mode_word,
                                  input int d, input int m,
                                  input logic [CFG_DATA_W-1:0] manual_word);
        write_reg(CFG_FAN_MODE, mode_word);
        write_reg(CFG_DESIRED, CFG_DATA_W'(d));
        write_reg(CFG_MAX, CFG_DATA_W'(m));
        write_reg(CFG_MANUAL_PCT, manual_word);
        band_lo = clamp12(((d < m) ? d : m) - 48);
        band_hi = clamp12(((d < m) ? m : d) + 48);
        phases++;
    endtask

    // random settings, mostly with desired below max
    task automatic pick_settings();
        int d;
        int m;
        int tmp;
        logic [CFG_DATA_W-1:0] mode_word;
        logic [CFG_DATA_W-1:0] manual_word;
        d = pick_temp();
        m = pick_temp();
        if ($urandom_range(0, 7) != 0 && d > m)
        begin
            tmp = d;
            d   = m;
            m   = tmp;
        end
        mode_word   = CFG_DATA_W'($urandom_range(0, 4095));
        manual_word = CFG_DATA_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) != 0)
            manual_word[PCT_W-1:0] = PCT_W'($urandom_range(0, 100));
        apply_settings(mode_word, d, m, manual_word);
    endtask

    // let every expected beat arrive before touching registers
    task automatic drain();
        sample_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result side: random stalls, every beat checked
    initial
    begin
        int stall;
        fan_result_t got;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : int'($urandom_range(0, 14));
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
            got.pct   = result_if.fan_percent;
            got.duty  = result_if.fan_duty;
            got.alarm = result_if.alarm_on;
            got.led   = result_if.alarm_led;
            got.filt  = result_if.avg_temp;
            sb.check_result(got);
        end
    end

    // stimulus
    initial
    begin
        int seq[$];
        int n;
        int base;
        int v;
        sb         = new();
        items_sent = 0;
        phases     = 0;
        tx_calm    = 0;
        rx_calm    = 0;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_FAN_MODE;
        cfg_data              <= '0;
        sample_if.valid       <= 1'b0;
        sample_if.temp_sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first sample loads, band, alarm with led toggling
        seq = '{448, 449, 2047, 2047, 2047, 2047, -2048, -2048, 0, -1};
        foreach (seq[k])
            send_sample(TEMP_W'(seq[k]));
        drain();

        // manual mode with percent above 100, other word bits set
        apply_settings(12'hFFF, 100, 2047, 12'hFFF);
        seq = '{2047, 1000, -2048};
        foreach (seq[k])
            send_sample(TEMP_W'(seq[k]));
        drain();

        // desired above max in auto mode
        tx_calm = 1;
        rx_calm = 1;
        apply_settings(12'h000, 2047, -2048, 12'h000);
        seq = '{-2048, -2048, 0};
        foreach (seq[k])
            send_sample(TEMP_W'(seq[k]));
        drain();

        // desired equal to max
        tx_calm = 0;
        apply_settings(12'h000, 0, 0, 12'h064);
        seq = '{0, 0, 5, -5};
        foreach (seq[k])
            send_sample(TEMP_W'(seq[k]));
        drain();

        // widest band
        rx_calm = 0;
        apply_settings(12'h000, -2048, 2047, 12'h032);
        seq = '{2047, -2048};
        foreach (seq[k])
            send_sample(TEMP_W'(seq[k]));
        drain();

        // random phases: samples wander around the band, some noise
        n = items_sent + RANDOM_ITEMS;
        while (items_sent < n)
        begin
            pick_settings();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            base = band_lo + int'($urandom_range(0, band_hi - band_lo));
            repeat ($urandom_range(60, 120))
            begin
                if ($urandom_range(0, 7) == 0)
                    base = band_lo + int'($urandom_range(0, band_hi - band_lo));
                if ($urandom_range(0, 7) == 0)
                    v = int'($urandom_range(0, 4095)) - 2048;
                else
                    v = clamp12(base + int'($urandom_range(0, 48)) - 24);
                send_sample(TEMP_W'(v));
            end
            drain();
        end

        $display("covered %0d samples over %0d register settings, %0d results checked",
                 items_sent, phases, sb.checked);
        $display("alarm on %0d results, proportional band on %0d", sb.alarms, sb.band_hits);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
